// ===== rtl/pidc_pkg.sv =====
package pidc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [23:0] PROP_GAIN_RST    = 24'd7864;
  localparam logic [23:0] INTEG_GAIN_RST   = 24'd22938;
  localparam logic [23:0] DERIV_GAIN_RST   = 24'd98;
  localparam logic [30:0] INTEG_LIMIT_RST  = 31'd13107;
  localparam logic [30:0] DRIVE_LIMIT_RST  = 31'd22938;
  localparam logic [23:0] FILTER_OMEGA_RST = 24'd643398;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_INTEG_LIMIT  = 3'd3,
    REG_DRIVE_LIMIT  = 3'd4,
    REG_FILTER_OMEGA = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] target;
    logic signed [31:0] sensed;
    logic        [23:0] step_time;
    logic               integrate_enable;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] tracking_error;
    logic signed [31:0] integral_term;
  } out_item_t;

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] integ_gain;
    logic [23:0] deriv_gain;
    logic [30:0] integ_limit;
    logic [30:0] drive_limit;
    logic [23:0] filter_omega;
  } cfg_t;

  typedef struct packed {
    logic is_clear;
    logic dt_zero;
    logic integ;
    logic omega_zero;
    logic seeded;
    logic acc_zero;
  } stat_t;

  typedef enum logic [4:0] {
    DC_NONE,
    DC_LOAD,
    DC_CLEAR,
    DC_SEED,
    DC_MUL_DIFF,
    DC_DERIV,
    DC_MUL_DLO,
    DC_MUL_DHI,
    DC_FSUM,
    DC_FUPD,
    DC_MUL_KI,
    DC_PSHIFT,
    DC_MUL_PLO,
    DC_MUL_PHI,
    DC_ISUM,
    DC_IUPD,
    DC_MUL_DEC,
    DC_DEC,
    DC_MUL_KP,
    DC_KPTERM,
    DC_MUL_KDLO,
    DC_MUL_KDHI,
    DC_KDSUM,
    DC_USUM,
    DC_DRIVE,
    DC_OUT
  } dp_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BRANCH,
    S_CLEAR,
    S_SEED,
    S_M_DIFF,
    S_DERIV,
    S_M_DLO,
    S_M_DHI,
    S_FSUM,
    S_FUPD,
    S_M_KI,
    S_PSHIFT,
    S_M_PLO,
    S_M_PHI,
    S_ISUM,
    S_IUPD,
    S_M_DEC,
    S_DEC,
    S_M_KP,
    S_KPTERM,
    S_M_KDLO,
    S_M_KDHI,
    S_KDSUM,
    S_USUM,
    S_DRIVE,
    S_OUT
  } ctrl_state_t;

endpackage

// ===== rtl/pidc_stream_if.sv =====
interface pidc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pid_axis_controller_top.sv =====
// Each accepted item runs to completion before the next is taken. The path through the
// sequence depends on whether the filter runs or is seeded or bypassed, and on whether
// the integral accumulates, unwinds or stays zero; clear items and zero time step items
// take short paths. All products come from the single shared 34 x 25 bit multiplier, and
// a result still held on a stalled output keeps the controller in its output state.
// Synchronous active-high reset restores the register defaults and zeroes the integral,
// filter, seed flag and held drive and error; the sequencer returns to idle, so no clearing pass is needed.
module pid_axis_controller_top
  import pidc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  pidc_stream_if.sink           req,
  pidc_stream_if.source         rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  stat_t     stat;
  dp_cmd_t   cmd;
  in_item_t  item;
  out_item_t result;

  assign item     = req.data;
  assign rsp.data = result;

  pidc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pidc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .cfg    (cfg),
    .stat   (stat),
    .result (result)
  );

endmodule

// ===== rtl/pidc_regs.sv =====
module pidc_regs
  import pidc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain    <= PROP_GAIN_RST;
      cfg.integ_gain   <= INTEG_GAIN_RST;
      cfg.deriv_gain   <= DERIV_GAIN_RST;
      cfg.integ_limit  <= INTEG_LIMIT_RST;
      cfg.drive_limit  <= DRIVE_LIMIT_RST;
      cfg.filter_omega <= FILTER_OMEGA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:    cfg.prop_gain    <= cfg_data[23:0];
        REG_INTEG_GAIN:   cfg.integ_gain   <= cfg_data[23:0];
        REG_DERIV_GAIN:   cfg.deriv_gain   <= cfg_data[23:0];
        REG_INTEG_LIMIT:  cfg.integ_limit  <= cfg_data[30:0];
        REG_DRIVE_LIMIT:  cfg.drive_limit  <= cfg_data[30:0];
        REG_FILTER_OMEGA: cfg.filter_omega <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/pidc_dp.sv =====
module pidc_dp
  import pidc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output stat_t     stat,
  output out_item_t result
);

  localparam logic [33:0] ONE_Q24     = 34'd16777216;
  localparam logic [33:0] UNWIND_RATE = 34'd1000;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v[40:31] == {10{v[31]}}) begin
      r = v[31:0];
    end else begin
      r = v[40] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // Architectural state.
  logic signed [31:0] acc;
  logic signed [31:0] filtered;
  logic               seeded;
  logic signed [31:0] last_drive;
  logic signed [31:0] last_error;

  // Item and working registers.
  logic               is_clear;
  logic               integ;
  logic signed [31:0] sensed;
  logic        [23:0] dt;
  logic        [23:0] scale;
  logic signed [31:0] err;
  logic signed [32:0] diff;
  logic signed [39:0] deriv;
  logic signed [39:0] p;
  logic signed [58:0] prod;
  logic signed [63:0] accw;
  logic signed [39:0] kpterm;
  logic signed [49:0] u;

  logic signed [32:0] err_wide;
  logic signed [32:0] diff_wide;
  logic        [33:0] dt1000;
  logic        [23:0] scale_next;
  logic        [31:0] mag;
  logic        [31:0] magd;
  logic signed [31:0] dec_val;
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [63:0] prod_x;
  logic signed [63:0] accw_sum;
  logic signed [63:0] accw_s24;
  logic signed [63:0] accw_s16;
  logic signed [58:0] dshift;
  logic signed [58:0] pshift;
  logic signed [39:0] deriv_sat;
  logic signed [40:0] fsum;
  logic signed [40:0] isum;
  logic signed [40:0] ilim_s;
  logic signed [31:0] iclamp;
  logic signed [49:0] usum;
  logic signed [49:0] dlim_s;
  logic signed [31:0] dclamp;

  assign err_wide   = 33'(item.target) - 33'(item.sensed);
  assign diff_wide  = 33'(item.sensed) - 33'(filtered);
  assign dt1000     = 34'(item.step_time) * UNWIND_RATE;
  assign scale_next = (dt1000 >= ONE_Q24) ? 24'd0 : 24'(ONE_Q24 - dt1000);

  assign mag     = acc[31] ? (32'd0 - acc) : acc;
  assign magd    = {1'b0, prod[54:24]};
  assign dec_val = acc[31] ? $signed(32'd0 - magd) : $signed(magd);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd)
      DC_MUL_DIFF: begin
        mul_a = 34'(diff);
        mul_b = $signed({1'b0, cfg.filter_omega});
      end
      DC_MUL_DLO: begin
        mul_a = $signed({14'd0, deriv[19:0]});
        mul_b = $signed({1'b0, dt});
      end
      DC_MUL_DHI: begin
        mul_a = 34'($signed(deriv[39:20]));
        mul_b = $signed({1'b0, dt});
      end
      DC_MUL_KI: begin
        mul_a = 34'(err);
        mul_b = $signed({1'b0, cfg.integ_gain});
      end
      DC_MUL_PLO: begin
        mul_a = $signed({14'd0, p[19:0]});
        mul_b = $signed({1'b0, dt});
      end
      DC_MUL_PHI: begin
        mul_a = 34'($signed(p[39:20]));
        mul_b = $signed({1'b0, dt});
      end
      DC_MUL_DEC: begin
        mul_a = $signed({2'd0, mag});
        mul_b = $signed({1'b0, scale});
      end
      DC_MUL_KP: begin
        mul_a = 34'(err);
        mul_b = $signed({1'b0, cfg.prop_gain});
      end
      DC_MUL_KDLO: begin
        mul_a = $signed({14'd0, deriv[19:0]});
        mul_b = $signed({1'b0, cfg.deriv_gain});
      end
      DC_MUL_KDHI: begin
        mul_a = 34'($signed(deriv[39:20]));
        mul_b = $signed({1'b0, cfg.deriv_gain});
      end
      default: begin
      end
    endcase
  end

  assign prod_x   = 64'(prod);
  assign accw_sum = (prod_x <<< 20) + accw;
  assign accw_s24 = accw >>> 24;
  assign accw_s16 = accw >>> 16;
  assign dshift   = prod >>> 12;
  assign pshift   = prod >>> 16;

  always_comb begin
    if (dshift[58:39] == {20{dshift[39]}}) begin
      deriv_sat = dshift[39:0];
    end else begin
      deriv_sat = dshift[58] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end
  end

  assign fsum   = 41'(filtered) + $signed(accw_s24[40:0]);
  assign isum   = 41'(acc) + $signed(accw_s24[40:0]);
  assign ilim_s = $signed({10'd0, cfg.integ_limit});

  always_comb begin
    if (isum > ilim_s) begin
      iclamp = ilim_s[31:0];
    end else if (isum < -ilim_s) begin
      iclamp = 32'(-ilim_s);
    end else begin
      iclamp = isum[31:0];
    end
  end

  assign usum   = 50'(kpterm) + 50'(acc) - $signed(accw_s16[49:0]);
  assign dlim_s = $signed({19'd0, cfg.drive_limit});

  always_comb begin
    if (u > dlim_s) begin
      dclamp = dlim_s[31:0];
    end else if (u < -dlim_s) begin
      dclamp = 32'(-dlim_s);
    end else begin
      dclamp = u[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      filtered   <= '0;
      seeded     <= 1'b0;
      last_drive <= '0;
      last_error <= '0;
    end else begin
      case (cmd)
        DC_CLEAR: begin
          acc        <= '0;
          filtered   <= '0;
          seeded     <= 1'b0;
          last_drive <= '0;
          last_error <= '0;
        end
        DC_SEED: begin
          filtered <= sensed;
          seeded   <= 1'b1;
        end
        DC_FUPD:  filtered <= sat32(fsum);
        DC_IUPD:  acc <= iclamp;
        DC_DEC:   acc <= dec_val;
        DC_DRIVE: begin
          last_drive <= dclamp;
          last_error <= err;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      DC_LOAD: begin
        is_clear <= item.op;
        integ    <= item.integrate_enable;
        sensed   <= item.sensed;
        dt       <= item.step_time;
        scale    <= scale_next;
        err      <= sat32(41'(err_wide));
        diff     <= diff_wide;
        deriv    <= '0;
      end
      DC_MUL_DIFF, DC_MUL_DLO, DC_MUL_KI, DC_MUL_PLO, DC_MUL_DEC, DC_MUL_KP,
      DC_MUL_KDLO: begin
        prod <= 59'(mul_a) * 59'(mul_b);
      end
      DC_MUL_DHI, DC_MUL_PHI, DC_MUL_KDHI: begin
        accw <= prod_x;
        prod <= 59'(mul_a) * 59'(mul_b);
      end
      DC_DERIV:  deriv  <= deriv_sat;
      DC_PSHIFT: p      <= pshift[39:0];
      DC_KPTERM: kpterm <= pshift[39:0];
      DC_FSUM, DC_ISUM, DC_KDSUM: accw <= accw_sum;
      DC_USUM:   u <= usum;
      DC_OUT: begin
        result.drive          <= last_drive;
        result.tracking_error <= last_error;
        result.integral_term  <= acc;
      end
      default: begin
      end
    endcase
  end

  assign stat.is_clear   = is_clear;
  assign stat.dt_zero    = (dt == 24'd0);
  assign stat.integ      = integ;
  assign stat.omega_zero = (cfg.filter_omega == 24'd0);
  assign stat.seeded     = seeded;
  assign stat.acc_zero   = (acc == 32'sd0);

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    cmd == DC_CLEAR |=> acc == 32'sd0 && filtered == 32'sd0 && !seeded &&
                        last_drive == 32'sd0 && last_error == 32'sd0)
    else $error("State not cleared after a clear item.");

  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    cmd == DC_IUPD |=> acc <= $past(ilim_s) && acc >= -$past(ilim_s))
    else $error("Integral left its clamp range.");

endmodule

// ===== rtl/pidc_ctrl.sv =====
module pidc_ctrl
  import pidc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  input  stat_t   stat,
  output dp_cmd_t cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  ctrl_state_t integ_entry;
  logic        out_valid;

  always_comb begin
    if (stat.integ) begin
      integ_entry = S_M_KI;
    end else if (!stat.acc_zero) begin
      integ_entry = S_M_DEC;
    end else begin
      integ_entry = S_M_KP;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_BRANCH;
        end
      end
      S_BRANCH: begin
        if (stat.is_clear) begin
          state_next = S_CLEAR;
        end else if (stat.dt_zero) begin
          state_next = S_OUT;
        end else if (stat.omega_zero || !stat.seeded) begin
          state_next = S_SEED;
        end else begin
          state_next = S_M_DIFF;
        end
      end
      S_CLEAR:  state_next = S_OUT;
      S_SEED:   state_next = integ_entry;
      S_M_DIFF: state_next = S_DERIV;
      S_DERIV:  state_next = S_M_DLO;
      S_M_DLO:  state_next = S_M_DHI;
      S_M_DHI:  state_next = S_FSUM;
      S_FSUM:   state_next = S_FUPD;
      S_FUPD:   state_next = integ_entry;
      S_M_KI:   state_next = S_PSHIFT;
      S_PSHIFT: state_next = S_M_PLO;
      S_M_PLO:  state_next = S_M_PHI;
      S_M_PHI:  state_next = S_ISUM;
      S_ISUM:   state_next = S_IUPD;
      S_IUPD:   state_next = S_M_KP;
      S_M_DEC:  state_next = S_DEC;
      S_DEC:    state_next = S_M_KP;
      S_M_KP:   state_next = S_KPTERM;
      S_KPTERM: state_next = S_M_KDLO;
      S_M_KDLO: state_next = S_M_KDHI;
      S_M_KDHI: state_next = S_KDSUM;
      S_KDSUM:  state_next = S_USUM;
      S_USUM:   state_next = S_DRIVE;
      S_DRIVE:  state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = DC_NONE;
    case (state)
      S_IDLE:   cmd = req_valid ? DC_LOAD : DC_NONE;
      S_CLEAR:  cmd = DC_CLEAR;
      S_SEED:   cmd = DC_SEED;
      S_M_DIFF: cmd = DC_MUL_DIFF;
      S_DERIV:  cmd = DC_DERIV;
      S_M_DLO:  cmd = DC_MUL_DLO;
      S_M_DHI:  cmd = DC_MUL_DHI;
      S_FSUM:   cmd = DC_FSUM;
      S_FUPD:   cmd = DC_FUPD;
      S_M_KI:   cmd = DC_MUL_KI;
      S_PSHIFT: cmd = DC_PSHIFT;
      S_M_PLO:  cmd = DC_MUL_PLO;
      S_M_PHI:  cmd = DC_MUL_PHI;
      S_ISUM:   cmd = DC_ISUM;
      S_IUPD:   cmd = DC_IUPD;
      S_M_DEC:  cmd = DC_MUL_DEC;
      S_DEC:    cmd = DC_DEC;
      S_M_KP:   cmd = DC_MUL_KP;
      S_KPTERM: cmd = DC_KPTERM;
      S_M_KDLO: cmd = DC_MUL_KDLO;
      S_M_KDHI: cmd = DC_MUL_KDHI;
      S_KDSUM:  cmd = DC_KDSUM;
      S_USUM:   cmd = DC_USUM;
      S_DRIVE:  cmd = DC_DRIVE;
      S_OUT:    cmd = (!out_valid || rsp_ready) ? DC_OUT : DC_NONE;
      default:  cmd = DC_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == DC_OUT) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;

  a_accept_branch: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == S_BRANCH)
    else $error("Accepted item did not start the sequence.");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd == DC_OUT |-> !out_valid || rsp_ready)
    else $error("Result register overwritten while still held.");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd == DC_OUT))
    else $error("Result valid raised without a result load.");

endmodule

// ===== tb/pidc_tb_pkg.sv =====
`timescale 1ns / 100ps
package pidc_tb_pkg;

  import pidc_pkg::*;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // An index past the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

endpackage

// ===== tb/pidc_drive_checker.sv =====
`timescale 1ns / 100ps
module pidc_drive_checker
  import pidc_pkg::*;
  import pidc_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pidc_stream_if                req,
  pidc_stream_if                rsp,
  output int                    errors,
  output int                    outstanding
);

  localparam longint DERIV_HI   = 64'sd549755813887;
  localparam longint DERIV_LO   = -DERIV_HI - 1;
  localparam longint I32_HI     = 64'sd2147483647;
  localparam longint I32_LO     = -I32_HI - 1;
  localparam longint ONE_Q24    = 64'sd16777216;
  localparam longint DECAY_RATE = 64'sd1000;

  logic        [23:0] kp;
  logic        [23:0] ki;
  logic        [23:0] kd;
  logic        [30:0] ilim;
  logic        [30:0] dlim;
  logic        [23:0] omega;
  logic signed [31:0] integ_state;
  logic signed [31:0] filt_state;
  logic signed [31:0] held_drive;
  logic signed [31:0] held_error;
  bit                 seeded;
  out_item_t          drive_due_q[$];
  int                 seen;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic out_item_t next_drive(input in_item_t it);
    out_item_t r;
    longint    dt;
    longint    err;
    longint    acc;
    longint    deriv;
    longint    diff;
    longint    p;
    longint    mag;
    longint    scale;
    longint    u;
    longint    lim;
    r = '0;
    deriv = 0;
    dt = longint'(it.step_time);
    if (it.op == OP_CLEAR) begin
      integ_state = '0;
      filt_state = '0;
      seeded = 1'b0;
      held_drive = '0;
      held_error = '0;
      return r;
    end
    if (dt == 0) begin
      r.drive = held_drive;
      r.tracking_error = held_error;
      r.integral_term = integ_state;
      return r;
    end
    if (omega == '0 || !seeded) begin
      filt_state = it.sensed;
      seeded = 1'b1;
    end else begin
      diff = longint'(it.sensed) - longint'(filt_state);
      deriv = clip((diff * longint'(omega)) >>> 12, DERIV_LO, DERIV_HI);
      u = clip(longint'(filt_state) + ((deriv * dt) >>> 24), I32_LO, I32_HI);
      filt_state = u[31:0];
    end
    err = clip(longint'(it.target) - longint'(it.sensed), I32_LO, I32_HI);
    acc = longint'(integ_state);
    if (it.integrate_enable) begin
      p = (longint'(ki) * err) >>> 16;
      lim = longint'(ilim);
      acc = clip(acc + ((p * dt) >>> 24), -lim, lim);
    end else if (acc != 0) begin
      scale = ONE_Q24 - DECAY_RATE * dt;
      if (scale < 0) scale = 0;
      mag = (acc < 0) ? -acc : acc;
      mag = (mag * scale) >>> 24;
      acc = (acc < 0) ? -mag : mag;
    end
    integ_state = acc[31:0];
    u = ((longint'(kp) * err) >>> 16) + acc - ((longint'(kd) * deriv) >>> 16);
    lim = longint'(dlim);
    u = clip(u, -lim, lim);
    held_drive = u[31:0];
    held_error = err[31:0];
    r.drive = held_drive;
    r.tracking_error = held_error;
    r.integral_term = integ_state;
    return r;
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 60) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    out_item_t got;
    out_item_t want;
    if (rst) begin
      kp = PROP_GAIN_RST;
      ki = INTEG_GAIN_RST;
      kd = DERIV_GAIN_RST;
      ilim = INTEG_LIMIT_RST;
      dlim = DRIVE_LIMIT_RST;
      omega = FILTER_OMEGA_RST;
      integ_state = '0;
      filt_state = '0;
      held_drive = '0;
      held_error = '0;
      seeded = 1'b0;
      drive_due_q.delete();
      seen = 0;
      errors = 0;
      outstanding = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:    kp = cfg_data[23:0];
          REG_INTEG_GAIN:   ki = cfg_data[23:0];
          REG_DERIV_GAIN:   kd = cfg_data[23:0];
          REG_INTEG_LIMIT:  ilim = cfg_data[30:0];
          REG_DRIVE_LIMIT:  dlim = cfg_data[30:0];
          REG_FILTER_OMEGA: omega = cfg_data[23:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) drive_due_q.push_back(next_drive(req.data));
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        seen++;
        if (drive_due_q.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", seen));
        end else begin
          want = drive_due_q.pop_front();
          if (got.drive !== want.drive)
            report($sformatf("result %0d drive %0d, expected %0d",
                             seen, got.drive, want.drive));
          if (got.tracking_error !== want.tracking_error)
            report($sformatf("result %0d tracking_error %0d, expected %0d",
                             seen, got.tracking_error, want.tracking_error));
          if (got.integral_term !== want.integral_term)
            report($sformatf("result %0d integral_term %0d, expected %0d",
                             seen, got.integral_term, want.integral_term));
        end
      end
      outstanding = drive_due_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

  import pidc_pkg::*;
  import pidc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    cycles = 0;
  bit                    tx_gappy;
  bit                    rx_gappy;
  longint                track_target;
  longint                track_meas;

  pidc_stream_if #(.data_t(in_item_t))  req_ch ();
  pidc_stream_if #(.data_t(out_item_t)) rsp_ch ();

  pid_axis_controller_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pidc_drive_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors      (fail_count),
    .outstanding (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 24'($urandom);
      default: return 24'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  function automatic logic [30:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 31'($urandom);
      default: return 31'($urandom_range(1, 1 << 22));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    longint   m;
    int       roll;
    it.op = ($urandom_range(0, 59) == 0) ? OP_CLEAR : OP_STEP;
    roll = $urandom_range(0, 99);
    if (roll < 4) track_target = longint'(int'($urandom));
    else if (roll < 12) track_target = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    m = track_meas + (track_target - track_meas) / 8
        + longint'($urandom_range(0, 4095)) - 2048;
    track_meas = (m > 64'sd2147483647) ? 64'sd2147483647 :
                 (m < -64'sd2147483648) ? -64'sd2147483648 : m;
    it.target = track_target[31:0];
    if (roll >= 98) it.sensed = 32'($urandom);
    else if (roll >= 96) it.sensed = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    else it.sensed = track_meas[31:0];
    case ($urandom_range(0, 19))
      0, 1: it.step_time = '0;
      2: it.step_time = '1;
      3: it.step_time = 24'($urandom);
      4: it.step_time = 24'($urandom_range(16700, 16850));
      default: it.step_time = 24'($urandom_range(1, 20000));
    endcase
    it.integrate_enable = ($urandom_range(0, 3) != 0);
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    if ($urandom_range(0, 63) == 0) tx_gappy = !tx_gappy;
    gap = (tx_gappy && $urandom_range(0, 2) != 0) ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic step(input logic op, input logic signed [31:0] tgt,
                      input logic signed [31:0] meas, input logic [23:0] dt,
                      input logic integ);
    in_item_t it;
    it.op = op;
    it.target = tgt;
    it.sensed = meas;
    it.step_time = dt;
    it.integrate_enable = integ;
    send_item(it);
  endtask

  task automatic finish_phase();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input cfg_t c);
    cfg_we <= 1'b1;
    put_reg(REG_PROP_GAIN, {7'($urandom), c.prop_gain});
    put_reg(REG_INTEG_GAIN, {7'($urandom), c.integ_gain});
    put_reg(REG_DERIV_GAIN, {7'($urandom), c.deriv_gain});
    put_reg(REG_INTEG_LIMIT, c.integ_limit);
    put_reg(REG_DRIVE_LIMIT, c.drive_limit);
    put_reg(REG_FILTER_OMEGA, {7'($urandom), c.filter_omega});
    put_reg(REG_UNUSED, 31'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin : receiver
    int hold;
    int taken;
    bit long_done;
    hold = 0;
    taken = 0;
    long_done = 0;
    rx_gappy = 1'b1;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp_ch.valid && rsp_ch.ready) taken++;
        if ($urandom_range(0, 255) == 0) rx_gappy = !rx_gappy;
        if (hold > 0) begin
          hold--;
        end else if (!long_done && taken >= 300) begin
          hold = 400;
          long_done = 1;
        end else if (rx_gappy && $urandom_range(0, 3) == 0) begin
          hold = pick_gap();
        end
        rsp_ch.ready <= (hold == 0);
      end
    end
  end

  initial begin : stimulus
    cfg_t c;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    tx_gappy = 1'b0;
    track_target = 0;
    track_meas = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: seeding, filtering, held results, unwinding and clears.
    step(OP_STEP, Q_ONE, Q_ONE / 2, 24'd1000, 1'b1);
    step(OP_STEP, Q_ONE, Q_ONE * 3 / 5, 24'd1000, 1'b1);
    step(OP_STEP, Q_ONE, Q_ONE * 7 / 10, 24'd0, 1'b1);
    step(OP_STEP, Q_ONE, Q_ONE * 9 / 10, 24'd2000, 1'b0);
    step(OP_STEP, Q_ONE, Q_ONE * 9 / 10, 24'hFFFFFF, 1'b0);
    step(OP_STEP, Q_ONE, Q_ONE, 24'd500, 1'b0);
    step(OP_STEP, Q_MAX, Q_MIN, 24'hFFFFFF, 1'b1);
    step(OP_STEP, Q_MIN, Q_MAX, 24'd1, 1'b1);
    step(OP_STEP, -32'sd1, 32'sd0, 24'hFFFFFF, 1'b1);
    step(OP_STEP, -Q_ONE, Q_ONE, 24'd3000, 1'b1);
    step(OP_STEP, -Q_ONE, Q_ONE, 24'd3000, 1'b1);
    step(OP_STEP, -Q_ONE, Q_ONE, 24'd3000, 1'b0);
    step(OP_CLEAR, 32'sd0, 32'sd0, 24'd0, 1'b0);
    step(OP_STEP, Q_ONE, Q_ONE, 24'd0, 1'b1);
    step(OP_STEP, Q_ONE * 2, Q_ONE, 24'd800, 1'b1);
    step(OP_CLEAR, Q_MAX, Q_MIN, 24'hFFFFFF, 1'b1);
    finish_phase();

    // Filter bypassed.
    c = '{prop_gain: 24'h010000, integ_gain: 24'h020000, deriv_gain: 24'h008000,
          integ_limit: 31'h0002_0000, drive_limit: 31'h7FFF_FFFF, filter_omega: 24'd0};
    program_regs(c);
    step(OP_STEP, Q_ONE, Q_ONE / 4, 24'd4000, 1'b1);
    step(OP_STEP, Q_ONE, Q_ONE / 2, 24'd4000, 1'b1);
    step(OP_STEP, Q_ONE, Q_MIN, 24'd4000, 1'b0);
    step(OP_STEP, Q_MIN, Q_MAX, 24'hFFFFFF, 1'b1);
    finish_phase();

    for (int p = 1; p <= 11; p++) begin
      case (p)
        1: c = '{prop_gain: '1, integ_gain: '1, deriv_gain: '1,
                 integ_limit: '1, drive_limit: '1, filter_omega: '1};
        2: c = '0;
        3: c = '{prop_gain: PROP_GAIN_RST, integ_gain: INTEG_GAIN_RST,
                 deriv_gain: DERIV_GAIN_RST, integ_limit: INTEG_LIMIT_RST,
                 drive_limit: DRIVE_LIMIT_RST, filter_omega: FILTER_OMEGA_RST};
        default: c = '{prop_gain: pick_gain(), integ_gain: pick_gain(),
                       deriv_gain: pick_gain(), integ_limit: pick_limit(),
                       drive_limit: pick_limit(), filter_omega: pick_gain()};
      endcase
      program_regs(c);
      repeat (160) send_item(random_item());
      finish_phase();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
